// ----- design/half_duplex_request_reply_link_fsm_core_defines.svh -----
// ----------------------------------------------------------------------------
// Link sequencer assertion macros
// Shared concurrent assertion forms for the link sequencer.
// ----------------------------------------------------------------------------
`ifndef HALF_DUPLEX_REQUEST_REPLY_LINK_FSM_CORE_DEFINES_SVH
`define HALF_DUPLEX_REQUEST_REPLY_LINK_FSM_CORE_DEFINES_SVH

// same-cycle implication under active-low reset
`define HDRL_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication under active-low reset
`define HDRL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/hdrl_pkg.sv -----
// ----------------------------------------------------------------------------
// Link sequencer package
// Transaction types, link context and event, state and result codes.
// ----------------------------------------------------------------------------
package hdrl_pkg;

  localparam logic [2:0] OP_TICK       = 3'd0;
  localparam logic [2:0] OP_SERVICE    = 3'd1;
  localparam logic [2:0] OP_SEND_REQ   = 3'd2;
  localparam logic [2:0] OP_TX_DONE    = 3'd3;
  localparam logic [2:0] OP_TX_TIMEOUT = 3'd4;
  localparam logic [2:0] OP_RX_DONE    = 3'd5;
  localparam logic [2:0] OP_RX_TIMEOUT = 3'd6;
  localparam logic [2:0] OP_RX_ERROR   = 3'd7;

  localparam logic [3:0] ST_INITIAL       = 4'd0;
  localparam logic [3:0] ST_WAIT_REQ      = 4'd1;
  localparam logic [3:0] ST_WAIT_REPLY    = 4'd2;
  localparam logic [3:0] ST_GOT_REQ       = 4'd3;
  localparam logic [3:0] ST_GOT_REPLY     = 4'd4;
  localparam logic [3:0] ST_SENDING_REQ   = 4'd5;
  localparam logic [3:0] ST_SENDING_REPLY = 4'd6;
  localparam logic [3:0] ST_SENT_REQ      = 4'd7;
  localparam logic [3:0] ST_SENT_REPLY    = 4'd8;

  localparam logic [2:0] CMD_NONE       = 3'd0;
  localparam logic [2:0] CMD_SLEEP      = 3'd1;
  localparam logic [2:0] CMD_SLEEP_RX   = 3'd2;
  localparam logic [2:0] CMD_SEND_REQ   = 3'd3;
  localparam logic [2:0] CMD_SEND_REPLY = 3'd4;

  localparam logic [2:0] OC_REPLY_RIGHT   = 3'd0;
  localparam logic [2:0] OC_REPLY_WRONG   = 3'd1;
  localparam logic [2:0] OC_NOT_NEEDED    = 3'd2;
  localparam logic [2:0] OC_REQ_TX_TMO    = 3'd3;
  localparam logic [2:0] OC_REPLY_TX_TMO  = 3'd4;
  localparam logic [2:0] OC_REPLY_WAIT_TMO = 3'd5;

  localparam logic [1:0] SS_NONE    = 2'd0;
  localparam logic [1:0] SS_PENDING = 2'd1;
  localparam logic [1:0] SS_INVALID = 2'd2;

  localparam int FLAG_TO_ME = 0;
  localparam int FLAG_WANTS = 1;
  localparam int FLAG_VALID = 2;

  localparam logic [15:0] AGE_MAX       = 16'hFFFF;
  localparam logic [15:0] STALE_DEFAULT = 16'd3500;

  typedef struct packed {
    logic [2:0]  op;
    logic [7:0]  rx_size;
    logic        frame_is_request;
    logic        frame_is_reply;
    logic        addressed_to_me;
    logic        wants_reply;
    logic        reply_valid;
    logic [7:0]  address;
    logic [15:0] payload;
  } in_t;

  typedef struct packed {
    logic [2:0]  radio_cmd;
    logic [7:0]  tx_address;
    logic [15:0] tx_payload;
    logic        tx_wants_reply;
    logic        outcome_valid;
    logic [2:0]  outcome_code;
    logic [15:0] outcome_payload;
    logic [1:0]  send_status;
    logic        notify_valid;
    logic [7:0]  notify_address;
    logic [15:0] notify_payload;
    logic [3:0]  machine_state;
  } out_t;

  typedef struct packed {
    logic [3:0]  link_state;
    logic [15:0] state_age_ms;
    logic [7:0]  held_source;
    logic [15:0] held_payload;
    logic [2:0]  held_flags;
    logic        sent_wants_reply;
  } ctx_t;

endpackage

// ----- design/half_duplex_request_reply_link_fsm_core.sv -----
// ----------------------------------------------------------------------------
// Half-duplex request/reply link sequencer
// Input register, one-pass event step against the link context, result
// register.
//
//   Channel  Handshake              Payload
//   in       in_valid / in_stall    in_data  (hdrl_pkg::in_t)
//   out      out_valid / out_stall  out_data (hdrl_pkg::out_t)
//   cfg      cfg_we                 cfg_wdata (stale timeout, ms)
//
// One transaction per cycle sustained while out_stall is low; a result passes
// the input register, then the event step into the result register.
// The step commits the link context in the same cycle it loads the result.
// Synchronous active-low reset; context clears, stale timeout returns to 3500.
// A stalled result holds; a full input register then stalls the input channel
// until the result register can load again.
// ----------------------------------------------------------------------------
module half_duplex_request_reply_link_fsm_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  hdrl_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output hdrl_pkg::out_t out_data,
  input  logic           cfg_we,
  input  logic [15:0]    cfg_wdata
);
  import hdrl_pkg::*;
  `include "half_duplex_request_reply_link_fsm_core_defines.svh"

  logic        in_vld_r;
  in_t         in_data_r;
  logic        out_vld_r;
  out_t        out_data_r;
  logic        can_load;
  logic        fire;
  ctx_t        ctx;
  ctx_t        ctx_nxt;
  out_t        res;
  logic [15:0] stale_timeout_ms;

  assign can_load = !out_vld_r || !out_stall;
  assign fire     = in_vld_r && can_load;
  assign in_stall = in_vld_r && !can_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        in_vld_r <= 1'b1;
      end else if (fire) begin
        in_vld_r <= 1'b0;
      end
      if (fire) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_data_r <= in_data;
    end
    if (fire) begin
      out_data_r <= res;
    end
  end

  hdrl_ctx u_ctx (
    .clk              (clk),
    .rst_n            (rst_n),
    .commit           (fire),
    .ctx_nxt          (ctx_nxt),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .ctx              (ctx),
    .stale_timeout_ms (stale_timeout_ms)
  );

  hdrl_step u_step (
    .item             (in_data_r),
    .ctx              (ctx),
    .stale_timeout_ms (stale_timeout_ms),
    .res              (res),
    .ctx_nxt          (ctx_nxt)
  );

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  `HDRL_ASSERT_NOW(a_tx_zero, clk, rst_n,
    out_vld_r && out_data_r.radio_cmd != CMD_SEND_REQ && out_data_r.radio_cmd != CMD_SEND_REPLY,
    out_data_r.tx_address == '0 && out_data_r.tx_payload == '0 && !out_data_r.tx_wants_reply,
    "tx fields set without a send command")
  `HDRL_ASSERT_NOW(a_outcome_zero, clk, rst_n,
    out_vld_r && !out_data_r.outcome_valid,
    out_data_r.outcome_code == '0 && out_data_r.outcome_payload == '0,
    "outcome fields set without an outcome")
  `HDRL_ASSERT_NOW(a_pending_state, clk, rst_n,
    out_vld_r && out_data_r.send_status == SS_PENDING,
    out_data_r.machine_state == ST_SENDING_REQ && out_data_r.radio_cmd == CMD_SEND_REQ,
    "pending send without entering sending-request state")
  `HDRL_ASSERT_NEXT(a_state_match, clk, rst_n,
    fire,
    out_vld_r && out_data_r.machine_state == ctx.link_state,
    "reported state differs from committed link state")
  `HDRL_ASSERT_NEXT(a_age_clear, clk, rst_n,
    fire && ctx_nxt.link_state != ctx.link_state,
    ctx.state_age_ms == '0,
    "state age not cleared on state change")

endmodule

// ----- design/hdrl_step.sv -----
// ----------------------------------------------------------------------------
// Link sequencer event step
// Decodes one event against the link context; gives result and next context.
// ----------------------------------------------------------------------------
module hdrl_step (
  input  hdrl_pkg::in_t  item,
  input  hdrl_pkg::ctx_t ctx,
  input  logic [15:0]    stale_timeout_ms,
  output hdrl_pkg::out_t res,
  output hdrl_pkg::ctx_t ctx_nxt
);
  import hdrl_pkg::*;

  always_comb begin
    logic [3:0] st;
    logic [15:0] age;
    logic       chg;
    ctx_nxt = ctx;
    res     = '0;
    st      = ctx.link_state;
    age     = ctx.state_age_ms;
    chg     = 1'b0;
    unique case (item.op)
      OP_TICK: begin
        if (age != AGE_MAX) begin
          age = age + 16'd1;
        end
      end
      OP_SERVICE: begin
        if (age > stale_timeout_ms) begin
          st  = ST_INITIAL;
          chg = 1'b1;
        end
        case (st)
          ST_INITIAL: begin
            res.radio_cmd = CMD_SLEEP_RX;
            st  = ST_WAIT_REQ;
            chg = 1'b1;
          end
          ST_GOT_REQ: begin
            chg = 1'b1;
            if (!ctx.held_flags[FLAG_TO_ME]) begin
              st = ST_INITIAL;
            end else begin
              res.notify_valid   = 1'b1;
              res.notify_address = ctx.held_source;
              res.notify_payload = ctx.held_payload;
              if (!ctx.held_flags[FLAG_WANTS]) begin
                st = ST_INITIAL;
              end else begin
                res.radio_cmd  = CMD_SEND_REPLY;
                res.tx_address = ctx.held_source;
                res.tx_payload = item.payload;
                st = ST_SENDING_REPLY;
              end
            end
          end
          ST_GOT_REPLY: begin
            if (!ctx.held_flags[FLAG_TO_ME]) begin
              res.radio_cmd = CMD_SLEEP_RX;
            end else begin
              res.outcome_valid = 1'b1;
              if (ctx.held_flags[FLAG_VALID]) begin
                res.outcome_code    = OC_REPLY_RIGHT;
                res.outcome_payload = ctx.held_payload;
              end else begin
                res.outcome_code = OC_REPLY_WRONG;
              end
              st  = ST_INITIAL;
              chg = 1'b1;
            end
          end
          ST_SENT_REQ: begin
            chg = 1'b1;
            if (!ctx.sent_wants_reply) begin
              res.radio_cmd     = CMD_SLEEP;
              res.outcome_valid = 1'b1;
              res.outcome_code  = OC_NOT_NEEDED;
              st = ST_INITIAL;
            end else begin
              res.radio_cmd = CMD_SLEEP_RX;
              st = ST_WAIT_REPLY;
            end
          end
          ST_SENT_REPLY: begin
            st  = ST_INITIAL;
            chg = 1'b1;
          end
          default: begin
          end
        endcase
      end
      OP_SEND_REQ: begin
        if (st != ST_WAIT_REQ) begin
          res.send_status = SS_INVALID;
        end else begin
          res.send_status    = SS_PENDING;
          res.radio_cmd      = CMD_SEND_REQ;
          res.tx_address     = item.address;
          res.tx_payload     = item.payload;
          res.tx_wants_reply = item.wants_reply;
          ctx_nxt.sent_wants_reply = item.wants_reply;
          st  = ST_SENDING_REQ;
          chg = 1'b1;
        end
      end
      OP_TX_DONE: begin
        if (st == ST_SENDING_REQ) begin
          st  = ST_SENT_REQ;
          chg = 1'b1;
        end else if (st == ST_SENDING_REPLY) begin
          st  = ST_SENT_REPLY;
          chg = 1'b1;
        end
      end
      OP_TX_TIMEOUT: begin
        if (st == ST_SENDING_REQ) begin
          res.outcome_valid = 1'b1;
          res.outcome_code  = OC_REQ_TX_TMO;
        end else if (st == ST_SENDING_REPLY) begin
          res.outcome_valid = 1'b1;
          res.outcome_code  = OC_REPLY_TX_TMO;
        end
        st  = ST_INITIAL;
        chg = 1'b1;
      end
      OP_RX_DONE: begin
        if (item.rx_size != 8'd0) begin
          if ((st == ST_WAIT_REQ && item.frame_is_request) ||
              (st == ST_WAIT_REPLY && item.frame_is_reply)) begin
            ctx_nxt.held_source  = item.address;
            ctx_nxt.held_payload = item.payload;
            ctx_nxt.held_flags   = {item.reply_valid, item.wants_reply,
                                    item.addressed_to_me};
            st  = (st == ST_WAIT_REQ) ? ST_GOT_REQ : ST_GOT_REPLY;
            chg = 1'b1;
          end else begin
            res.radio_cmd = CMD_SLEEP_RX;
          end
        end
      end
      OP_RX_TIMEOUT: begin
        if (st == ST_WAIT_REQ || st == ST_WAIT_REPLY) begin
          if (st == ST_WAIT_REPLY) begin
            res.outcome_valid = 1'b1;
            res.outcome_code  = OC_REPLY_WAIT_TMO;
          end
          res.radio_cmd = CMD_SLEEP_RX;
          st  = ST_WAIT_REQ;
          chg = 1'b1;
        end
      end
      OP_RX_ERROR: begin
        st  = ST_INITIAL;
        chg = 1'b1;
      end
      default: begin
      end
    endcase
    if (chg) begin
      age = '0;
    end
    ctx_nxt.link_state   = st;
    ctx_nxt.state_age_ms = age;
    res.machine_state    = st;
  end

endmodule

// ----- design/hdrl_ctx.sv -----
// ----------------------------------------------------------------------------
// Link sequencer context
// Holds link state, state age, held frame and the stale timeout register.
// ----------------------------------------------------------------------------
module hdrl_ctx (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           commit,
  input  hdrl_pkg::ctx_t ctx_nxt,
  input  logic           cfg_we,
  input  logic [15:0]    cfg_wdata,
  output hdrl_pkg::ctx_t ctx,
  output logic [15:0]    stale_timeout_ms
);
  import hdrl_pkg::*;

  ctx_t        ctx_r;
  logic [15:0] stale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctx_r   <= '0;
      stale_r <= STALE_DEFAULT;
    end else begin
      if (commit) begin
        ctx_r <= ctx_nxt;
      end
      if (cfg_we) begin
        stale_r <= cfg_wdata;
      end
    end
  end

  assign ctx              = ctx_r;
  assign stale_timeout_ms = stale_r;

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Link sequencer testbench
// Drives link events through the valid/stall input channel and predicts each
// result with a cycle-free model of the nine-state link machine. Directed
// tests walk the request, reply, timeout and stale-state paths. Randomized
// phases then follow the machine's own progress under several stale timeouts
// and several sender-idle and receiver-stall patterns.
// ----------------------------------------------------------------------------
module testbench;
  import hdrl_pkg::*;

  localparam logic [4:0] F_NONE = 5'b00000;
  localparam logic [4:0] F_REQ  = 5'b10000;
  localparam logic [4:0] F_REP  = 5'b01000;
  localparam logic [4:0] F_ME   = 5'b00100;
  localparam logic [4:0] F_WANT = 5'b00010;
  localparam logic [4:0] F_OK   = 5'b00001;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_t         in_data;
  logic        out_valid;
  logic        out_stall;
  out_t        out_data;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  ctx_t        ctx;
  logic [15:0] stale_limit;
  out_t        expected_results[$];
  int          errors;
  int          idle_pct;
  int          stall_pct;

  half_duplex_request_reply_link_fsm_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #2000000;
    $display("testbench NOT OK");
    $finish;
  end

  function automatic void enter_state(logic [3:0] s);
    ctx.link_state   = s;
    ctx.state_age_ms = '0;
  endfunction

  function automatic out_t predict_link_step(in_t ev);
    out_t r;
    r = '0;
    case (ev.op)
      OP_TICK: begin
        if (ctx.state_age_ms != AGE_MAX) ctx.state_age_ms = ctx.state_age_ms + 16'd1;
      end
      OP_SERVICE: begin
        if (ctx.state_age_ms > stale_limit) enter_state(ST_INITIAL);
        case (ctx.link_state)
          ST_INITIAL: begin
            r.radio_cmd = CMD_SLEEP_RX;
            enter_state(ST_WAIT_REQ);
          end
          ST_GOT_REQ: begin
            if (!ctx.held_flags[FLAG_TO_ME]) begin
              enter_state(ST_INITIAL);
            end else begin
              r.notify_valid   = 1'b1;
              r.notify_address = ctx.held_source;
              r.notify_payload = ctx.held_payload;
              if (ctx.held_flags[FLAG_WANTS]) begin
                r.radio_cmd  = CMD_SEND_REPLY;
                r.tx_address = ctx.held_source;
                r.tx_payload = ev.payload;
                enter_state(ST_SENDING_REPLY);
              end else begin
                enter_state(ST_INITIAL);
              end
            end
          end
          ST_GOT_REPLY: begin
            if (!ctx.held_flags[FLAG_TO_ME]) begin
              r.radio_cmd = CMD_SLEEP_RX;
            end else begin
              r.outcome_valid = 1'b1;
              if (ctx.held_flags[FLAG_VALID]) begin
                r.outcome_code    = OC_REPLY_RIGHT;
                r.outcome_payload = ctx.held_payload;
              end else begin
                r.outcome_code = OC_REPLY_WRONG;
              end
              enter_state(ST_INITIAL);
            end
          end
          ST_SENT_REQ: begin
            if (!ctx.sent_wants_reply) begin
              r.radio_cmd     = CMD_SLEEP;
              r.outcome_valid = 1'b1;
              r.outcome_code  = OC_NOT_NEEDED;
              enter_state(ST_INITIAL);
            end else begin
              r.radio_cmd = CMD_SLEEP_RX;
              enter_state(ST_WAIT_REPLY);
            end
          end
          ST_SENT_REPLY: enter_state(ST_INITIAL);
          default: ;
        endcase
      end
      OP_SEND_REQ: begin
        if (ctx.link_state != ST_WAIT_REQ) begin
          r.send_status = SS_INVALID;
        end else begin
          r.send_status        = SS_PENDING;
          r.radio_cmd          = CMD_SEND_REQ;
          r.tx_address         = ev.address;
          r.tx_payload         = ev.payload;
          r.tx_wants_reply     = ev.wants_reply;
          ctx.sent_wants_reply = ev.wants_reply;
          enter_state(ST_SENDING_REQ);
        end
      end
      OP_TX_DONE: begin
        if (ctx.link_state == ST_SENDING_REQ) enter_state(ST_SENT_REQ);
        else if (ctx.link_state == ST_SENDING_REPLY) enter_state(ST_SENT_REPLY);
      end
      OP_TX_TIMEOUT: begin
        if (ctx.link_state == ST_SENDING_REQ) begin
          r.outcome_valid = 1'b1;
          r.outcome_code  = OC_REQ_TX_TMO;
        end else if (ctx.link_state == ST_SENDING_REPLY) begin
          r.outcome_valid = 1'b1;
          r.outcome_code  = OC_REPLY_TX_TMO;
        end
        enter_state(ST_INITIAL);
      end
      OP_RX_DONE: begin
        if (ev.rx_size != 8'd0) begin
          if ((ctx.link_state == ST_WAIT_REQ && ev.frame_is_request) ||
              (ctx.link_state == ST_WAIT_REPLY && ev.frame_is_reply)) begin
            ctx.held_source            = ev.address;
            ctx.held_payload           = ev.payload;
            ctx.held_flags[FLAG_TO_ME] = ev.addressed_to_me;
            ctx.held_flags[FLAG_WANTS] = ev.wants_reply;
            ctx.held_flags[FLAG_VALID] = ev.reply_valid;
            enter_state(ctx.link_state == ST_WAIT_REQ ? ST_GOT_REQ : ST_GOT_REPLY);
          end else begin
            r.radio_cmd = CMD_SLEEP_RX;
          end
        end
      end
      OP_RX_TIMEOUT: begin
        if (ctx.link_state == ST_WAIT_REQ || ctx.link_state == ST_WAIT_REPLY) begin
          if (ctx.link_state == ST_WAIT_REPLY) begin
            r.outcome_valid = 1'b1;
            r.outcome_code  = OC_REPLY_WAIT_TMO;
          end
          r.radio_cmd = CMD_SLEEP_RX;
          enter_state(ST_WAIT_REQ);
        end
      end
      OP_RX_ERROR: enter_state(ST_INITIAL);
    endcase
    r.machine_state = ctx.link_state;
    return r;
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : check_results
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("result transaction with nothing pending");
        errors++;
      end else begin
        want = expected_results.pop_front();
        check_field("radio_cmd", want.radio_cmd, out_data.radio_cmd);
        check_field("tx_address", want.tx_address, out_data.tx_address);
        check_field("tx_payload", want.tx_payload, out_data.tx_payload);
        check_field("tx_wants_reply", want.tx_wants_reply, out_data.tx_wants_reply);
        check_field("outcome_valid", want.outcome_valid, out_data.outcome_valid);
        check_field("outcome_code", want.outcome_code, out_data.outcome_code);
        check_field("outcome_payload", want.outcome_payload, out_data.outcome_payload);
        check_field("send_status", want.send_status, out_data.send_status);
        check_field("notify_valid", want.notify_valid, out_data.notify_valid);
        check_field("notify_address", want.notify_address, out_data.notify_address);
        check_field("notify_payload", want.notify_payload, out_data.notify_payload);
        check_field("machine_state", want.machine_state, out_data.machine_state);
      end
    end
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic send_event(input in_t ev);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_data  <= ev;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    expected_results.push_back(predict_link_step(ev));
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_stale(input logic [15:0] ms);
    drain_results();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= ms;
    @(negedge clk);
    cfg_we      <= 1'b0;
    stale_limit  = ms;
  endtask

  function automatic in_t make_event(logic [2:0] op, logic [4:0] flags, logic [7:0] addr,
                                     logic [15:0] pay, logic [7:0] size);
    in_t e;
    e.op      = op;
    e.rx_size = size;
    {e.frame_is_request, e.frame_is_reply, e.addressed_to_me, e.wants_reply,
     e.reply_valid} = flags;
    e.address = addr;
    e.payload = pay;
    return e;
  endfunction

  task automatic fire_event(input logic [2:0] op, input logic [4:0] flags,
                            input logic [7:0] addr, input logic [15:0] pay,
                            input logic [7:0] size);
    send_event(make_event(op, flags, addr, pay, size));
  endtask

  function automatic in_t noise_event();
    in_t e;
    e.op      = 3'($urandom_range(7));
    e.rx_size = 8'($urandom());
    {e.frame_is_request, e.frame_is_reply, e.addressed_to_me, e.wants_reply,
     e.reply_valid} = 5'($urandom());
    e.address = 8'($urandom());
    e.payload = 16'($urandom());
    return e;
  endfunction

  // steer toward the transaction that advances the current state
  function automatic in_t next_event();
    in_t e;
    int  pick;
    e = noise_event();
    if ($urandom_range(99) < 20) return e;
    pick = $urandom_range(99);
    case (ctx.link_state)
      ST_INITIAL: e.op = (pick < 85) ? OP_SERVICE : OP_TICK;
      ST_WAIT_REQ: begin
        if (pick < 45) begin
          e.op = OP_SEND_REQ;
        end else if (pick < 85) begin
          e.op               = OP_RX_DONE;
          e.frame_is_request = 1'b1;
          e.rx_size          = 8'($urandom_range(255, 1));
        end else if (pick < 95) begin
          e.op = OP_RX_TIMEOUT;
        end else begin
          e.op = OP_TICK;
        end
      end
      ST_WAIT_REPLY: begin
        if (pick < 75) begin
          e.op             = OP_RX_DONE;
          e.frame_is_reply = 1'b1;
          e.rx_size        = 8'($urandom_range(255, 1));
        end else if (pick < 90) begin
          e.op = OP_RX_TIMEOUT;
        end else begin
          e.op = OP_TICK;
        end
      end
      ST_SENDING_REQ, ST_SENDING_REPLY: e.op = (pick < 85) ? OP_TX_DONE : OP_TX_TIMEOUT;
      default: e.op = (pick < 80) ? OP_SERVICE : OP_TICK;
    endcase
    return e;
  endfunction

  task automatic test_reply_path();
    fire_event(OP_SERVICE, F_NONE, 8'h00, 16'h0000, 8'd1);
    fire_event(OP_RX_DONE, F_REQ | F_ME | F_WANT, 8'hFF, 16'hFFFF, 8'd0);
    fire_event(OP_RX_DONE, F_REQ | F_REP | F_ME | F_WANT | F_OK, 8'hFF, 16'hFFFF, 8'hFF);
    fire_event(OP_SERVICE, F_NONE, 8'h00, 16'hFFFF, 8'd1);
    fire_event(OP_TX_DONE, F_NONE, 8'h00, 16'h0000, 8'd1);
    fire_event(OP_TX_DONE, F_NONE, 8'h00, 16'h0000, 8'd1);
    fire_event(OP_SERVICE, F_NONE, 8'h00, 16'h0000, 8'd1);
    fire_event(OP_SERVICE, F_NONE, 8'h00, 16'h0000, 8'd1);
    fire_event(OP_RX_DONE, F_REQ | F_ME, 8'h00, 16'h0000, 8'd1);
    fire_event(OP_SERVICE, F_NONE, 8'h00, 16'h0000, 8'd1);
    fire_event(OP_SERVICE, F_NONE, 8'h00, 16'h0000, 8'd1);
    fire_event(OP_RX_DONE, F_REQ, 8'h5A, 16'h1234, 8'd9);
    fire_event(OP_SERVICE, F_NONE, 8'h00, 16'h0000, 8'd1);
    fire_event(OP_SERVICE, F_NONE, 8'h00, 16'h0000, 8'd1);
    fire_event(OP_RX_DONE, F_REP | F_ME | F_OK, 8'hA5, 16'h4321, 8'd3);
  endtask

  task automatic test_request_path();
    fire_event(OP_SEND_REQ, F_WANT, 8'hFF, 16'hFFFF, 8'd0);
    fire_event(OP_SEND_REQ, F_WANT, 8'h11, 16'h2222, 8'd0);
    fire_event(OP_TX_DONE, F_NONE, 8'h00, 16'h0000, 8'd1);
    fire_event(OP_SERVICE, F_NONE, 8'h00, 16'h0000, 8'd1);
    fire_event(OP_RX_DONE, F_REQ | F_ME | F_OK, 8'h33, 16'h4444, 8'd5);
    fire_event(OP_RX_DONE, F_REP | F_ME | F_OK, 8'hFF, 16'hFFFF, 8'd5);
    fire_event(OP_SERVICE, F_NONE, 8'h00, 16'h0000, 8'd1);
    fire_event(OP_SEND_REQ, F_WANT, 8'h12, 16'h3456, 8'd0);
    fire_event(OP_SERVICE, F_NONE, 8'h00, 16'h0000, 8'd1);
    fire_event(OP_SEND_REQ, F_NONE, 8'h00, 16'h0000, 8'd0);
    fire_event(OP_TX_DONE, F_NONE, 8'h00, 16'h0000, 8'd1);
    fire_event(OP_SERVICE, F_NONE, 8'h00, 16'h0000, 8'd1);
    fire_event(OP_SERVICE, F_NONE, 8'h00, 16'h0000, 8'd1);
    fire_event(OP_SEND_REQ, F_WANT, 8'h77, 16'h8888, 8'd0);
    fire_event(OP_TX_DONE, F_NONE, 8'h00, 16'h0000, 8'd1);
    fire_event(OP_SERVICE, F_NONE, 8'h00, 16'h0000, 8'd1);
    fire_event(OP_RX_DONE, F_REP | F_ME, 8'h77, 16'h9999, 8'd5);
    fire_event(OP_SERVICE, F_NONE, 8'h00, 16'h0000, 8'd1);
  endtask

  task automatic test_timeouts();
    fire_event(OP_RX_TIMEOUT, F_NONE, 8'h00, 16'h0000, 8'd1);
    fire_event(OP_SERVICE, F_NONE, 8'h00, 16'h0000, 8'd1);
    fire_event(OP_SEND_REQ, F_WANT, 8'h21, 16'h0101, 8'd0);
    fire_event(OP_TX_TIMEOUT, F_NONE, 8'h00, 16'h0000, 8'd1);
    fire_event(OP_SERVICE, F_NONE, 8'h00, 16'h0000, 8'd1);
    fire_event(OP_RX_DONE, F_REQ | F_ME | F_WANT, 8'h42, 16'h0202, 8'd7);
    fire_event(OP_SERVICE, F_NONE, 8'h00, 16'hBEEF, 8'd1);
    fire_event(OP_TX_TIMEOUT, F_NONE, 8'h00, 16'h0000, 8'd1);
    fire_event(OP_TX_TIMEOUT, F_NONE, 8'h00, 16'h0000, 8'd1);
    fire_event(OP_SERVICE, F_NONE, 8'h00, 16'h0000, 8'd1);
    fire_event(OP_SEND_REQ, F_WANT, 8'h63, 16'h0303, 8'd0);
    fire_event(OP_TX_DONE, F_NONE, 8'h00, 16'h0000, 8'd1);
    fire_event(OP_SERVICE, F_NONE, 8'h00, 16'h0000, 8'd1);
    fire_event(OP_RX_TIMEOUT, F_NONE, 8'h00, 16'h0000, 8'd1);
    fire_event(OP_RX_TIMEOUT, F_NONE, 8'h00, 16'h0000, 8'd1);
    fire_event(OP_RX_ERROR, F_NONE, 8'h00, 16'h0000, 8'd1);
  endtask

  task automatic test_stale_timeout();
    write_stale(16'd1);
    fire_event(OP_SERVICE, F_NONE, 8'h00, 16'h0000, 8'd1);
    fire_event(OP_TICK, F_NONE, 8'h00, 16'h0000, 8'd1);
    fire_event(OP_SERVICE, F_NONE, 8'h00, 16'h0000, 8'd1);
    fire_event(OP_TICK, F_NONE, 8'h00, 16'h0000, 8'd1);
    fire_event(OP_TICK, F_NONE, 8'h00, 16'h0000, 8'd1);
    fire_event(OP_SERVICE, F_NONE, 8'h00, 16'h0000, 8'd1);
    // reply for another node: radio restarts, age keeps running until stale
    fire_event(OP_SEND_REQ, F_WANT, 8'h09, 16'h0909, 8'd0);
    fire_event(OP_TX_DONE, F_NONE, 8'h00, 16'h0000, 8'd1);
    fire_event(OP_SERVICE, F_NONE, 8'h00, 16'h0000, 8'd1);
    fire_event(OP_RX_DONE, F_REP | F_OK, 8'h09, 16'h5555, 8'd4);
    fire_event(OP_SERVICE, F_NONE, 8'h00, 16'h0000, 8'd1);
    fire_event(OP_TICK, F_NONE, 8'h00, 16'h0000, 8'd1);
    fire_event(OP_TICK, F_NONE, 8'h00, 16'h0000, 8'd1);
    fire_event(OP_SERVICE, F_NONE, 8'h00, 16'h0000, 8'd1);
  endtask

  task automatic test_age_threshold();
    in_t e;
    write_stale(16'd40);
    repeat (40) begin
      e    = noise_event();
      e.op = OP_TICK;
      send_event(e);
    end
    fire_event(OP_SERVICE, F_NONE, 8'h00, 16'h0000, 8'd1);
    fire_event(OP_TICK, F_NONE, 8'h00, 16'h0000, 8'd1);
    fire_event(OP_SERVICE, F_NONE, 8'h00, 16'h0000, 8'd1);
  endtask

  task automatic test_random(input int send_idle, input int recv_stall,
                             input logic [15:0] stale, input bit hold_off);
    in_t e;
    int  sent;
    bit  paused;
    write_stale(stale);
    idle_pct  = send_idle;
    stall_pct = recv_stall;
    sent      = 0;
    paused    = 1'b0;
    while (sent < 60) begin
      if (hold_off && !paused && sent >= 30) begin
        drain_results();
        paused = 1'b1;
      end
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(12, 1)) begin
          e    = noise_event();
          e.op = OP_TICK;
          send_event(e);
          sent++;
        end
      end else begin
        send_event(next_event());
        sent++;
      end
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_we      = 1'b0;
    cfg_wdata   = '0;
    errors      = 0;
    idle_pct    = 0;
    stall_pct   = 0;
    ctx         = '0;
    stale_limit = STALE_DEFAULT;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reply_path();
    test_request_path();
    idle_pct  = 26;
    stall_pct = 26;
    test_timeouts();
    test_stale_timeout();
    idle_pct  = 0;
    stall_pct = 0;
    test_age_threshold();

    test_random(0, 0, 16'hFFFF, 1'b0);
    test_random(57, 0, 16'($urandom_range(12, 2)), 1'b0);
    test_random(0, 57, 16'd1, 1'b1);
    test_random(26, 26, 16'($urandom_range(12, 2)), 1'b0);
    test_random(26, 26, STALE_DEFAULT, 1'b0);

    drain_results();
    repeat (8) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
